// ===== design/rcmw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmw_pkg
// Shared types, constants and arithmetic helpers for the radio pulse to
// mecanum wheel speed block.
// ----------------------------------------------------------------------------
package rcmw_pkg;

	// Field widths
	localparam int PULSE_W = 16;
	localparam int GAIN_W  = 24;
	localparam int WIDTH_W = 12;
	localparam int OFS_W   = WIDTH_W + 1;
	localparam int SPEED_W = 16;
	localparam int N_CH    = 3;
	localparam int N_WHEEL = 4;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Gain fraction bits and the scale divisor 4000 = 125 << 5
	localparam int GAIN_FRAC_BITS = 16;
	localparam int SCALE_SHIFT    = 5;
	localparam int SCALE_ODD      = 125;

	// Datapath widths
	localparam int PROD_W = GAIN_W + 1 + OFS_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W - 1;
	localparam int Y_W    = MAG_W - GAIN_FRAC_BITS - SCALE_SHIFT;

	// Reciprocal of 125: exact floor for every Y_W-bit value since the
	// rounding error times the largest value stays below 2^RECIP_K
	localparam int RECIP_K = Y_W + 7;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_K) + 64'(SCALE_ODD - 1)) / 64'(SCALE_ODD);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int QP_W    = Y_W + RECIP_W;
	localparam int Q_W     = QP_W - RECIP_K;

	// Reset values
	localparam logic [GAIN_W-1:0]  FORWARD_GAIN_RST    = 24'd12516452;
	localparam logic [GAIN_W-1:0]  LATERAL_GAIN_RST    = 24'd12516452;
	localparam logic [GAIN_W-1:0]  ROTATION_GAIN_RST   = 24'd6758885;
	localparam logic [WIDTH_W-1:0] CENTER_WIDTH_RST    = 12'd2000;
	localparam logic [WIDTH_W-1:0] DEADBAND_WIDTH_RST  = 12'd100;
	localparam logic [WIDTH_W-1:0] MAX_VALID_WIDTH_RST = 12'd4000;
	localparam logic [WIDTH_W-1:0] LAST_VALID_RST      = 12'd1500;

	// Channel and wheel slots
	localparam int CH_FORWARD  = 0;
	localparam int CH_LATERAL  = 1;
	localparam int CH_ROTATION = 2;

	localparam int WH_RIGHT_FRONT = 0;
	localparam int WH_LEFT_FRONT  = 1;
	localparam int WH_LEFT_REAR   = 2;
	localparam int WH_RIGHT_REAR  = 3;

	// Register indexes
	typedef enum logic [2:0] {
		REG_FORWARD_GAIN    = 3'd0,
		REG_LATERAL_GAIN    = 3'd1,
		REG_ROTATION_GAIN   = 3'd2,
		REG_CENTER_WIDTH    = 3'd3,
		REG_DEADBAND_WIDTH  = 3'd4,
		REG_MAX_VALID_WIDTH = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  forward_gain;
		logic [GAIN_W-1:0]  lateral_gain;
		logic [GAIN_W-1:0]  rotation_gain;
		logic [WIDTH_W-1:0] center_width;
		logic [WIDTH_W-1:0] deadband_width;
		logic [WIDTH_W-1:0] max_valid_width;
	} cfg_t;

	// Signed offset from center, zeroed when strictly inside the deadband
	function automatic logic signed [OFS_W-1:0] offset_db(
		input logic [WIDTH_W-1:0] w,
		input logic [WIDTH_W-1:0] center,
		input logic [WIDTH_W-1:0] deadband
	);
		logic signed [OFS_W-1:0] d;
		logic [OFS_W-1:0]        mag;
		d   = $signed({1'b0, w}) - $signed({1'b0, center});
		mag = d[OFS_W-1] ? OFS_W'(-d) : OFS_W'(d);
		if (mag < {1'b0, deadband}) begin
			d = '0;
		end
		return d;
	endfunction

	// Unsigned gain times signed offset
	function automatic logic signed [PROD_W-1:0] weigh(
		input logic [GAIN_W-1:0]        gain,
		input logic signed [OFS_W-1:0]  d
	);
		logic signed [GAIN_W:0] g;
		g = $signed({1'b0, gain});
		return g * d;
	endfunction

	// Sign extend a product to sum width
	function automatic logic signed [SUM_W-1:0] sext(input logic signed [PROD_W-1:0] p);
		return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
	endfunction

	// Quotient of the magnitude by 125, then sign and saturate
	function automatic logic signed [SPEED_W-1:0] wheel_speed(
		input logic           neg,
		input logic [Y_W-1:0] y
	);
		logic [QP_W-1:0]         prod;
		logic [Q_W-1:0]          q;
		logic [31:0]             q32;
		logic signed [SPEED_W-1:0] res;
		prod = QP_W'(y) * QP_W'(RECIP);
		q    = prod[QP_W-1:RECIP_K];
		q32  = 32'(q);
		if (neg) begin
			if (q32 > 32'd32768) begin
				res = 16'sh8000;
			end else begin
				res = SPEED_W'(-q32);
			end
		end else begin
			if (q32 > 32'd32767) begin
				res = 16'sh7fff;
			end else begin
				res = SPEED_W'(q32);
			end
		end
		return res;
	endfunction

endpackage

// ===== design/rcmw_pulse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmw_pulse_if
// Request channel carrying the three captured radio pulse widths.
// ----------------------------------------------------------------------------
interface rcmw_pulse_if;
	logic                        valid;
	logic                        ready;
	logic [rcmw_pkg::PULSE_W-1:0] forward_pulse;
	logic [rcmw_pkg::PULSE_W-1:0] lateral_pulse;
	logic [rcmw_pkg::PULSE_W-1:0] rotation_pulse;

	modport source (
		output valid, forward_pulse, lateral_pulse, rotation_pulse,
		input  ready
	);
	modport sink (
		input  valid, forward_pulse, lateral_pulse, rotation_pulse,
		output ready
	);
endinterface

// ===== design/rcmw_speed_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmw_speed_if
// Request channel carrying the four wheel speeds and the hold flags.
// ----------------------------------------------------------------------------
interface rcmw_speed_if;
	logic                                valid;
	logic                                ready;
	logic signed [rcmw_pkg::SPEED_W-1:0] right_front_speed;
	logic signed [rcmw_pkg::SPEED_W-1:0] left_front_speed;
	logic signed [rcmw_pkg::SPEED_W-1:0] left_rear_speed;
	logic signed [rcmw_pkg::SPEED_W-1:0] right_rear_speed;
	logic [rcmw_pkg::N_CH-1:0]           held_mask;

	modport source (
		output valid, right_front_speed, left_front_speed, left_rear_speed,
		       right_rear_speed, held_mask,
		input  ready
	);
	modport sink (
		input  valid, right_front_speed, left_front_speed, left_rear_speed,
		       right_rear_speed, held_mask,
		output ready
	);
endinterface

// ===== design/rcmw_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmw_regs
// APB-style configuration register file: gains, center, deadband and
// maximum valid pulse width.
// ----------------------------------------------------------------------------
module rcmw_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rcmw_pkg::ADDR_W-1:0]   paddr,
	input  logic [rcmw_pkg::DATA_W-1:0]   pwdata,
	output logic [rcmw_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output rcmw_pkg::cfg_t                cfg
);

	rcmw_pkg::reg_idx_t idx;
	logic               wr_en;
	rcmw_pkg::cfg_t     cfg_q;

	assign idx    = rcmw_pkg::reg_idx_t'(paddr[rcmw_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register, drop writes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.forward_gain    <= rcmw_pkg::FORWARD_GAIN_RST;
			cfg_q.lateral_gain    <= rcmw_pkg::LATERAL_GAIN_RST;
			cfg_q.rotation_gain   <= rcmw_pkg::ROTATION_GAIN_RST;
			cfg_q.center_width    <= rcmw_pkg::CENTER_WIDTH_RST;
			cfg_q.deadband_width  <= rcmw_pkg::DEADBAND_WIDTH_RST;
			cfg_q.max_valid_width <= rcmw_pkg::MAX_VALID_WIDTH_RST;
		end else if (wr_en) begin
			case (idx)
				rcmw_pkg::REG_FORWARD_GAIN:
					cfg_q.forward_gain <= pwdata[rcmw_pkg::GAIN_W-1:0];
				rcmw_pkg::REG_LATERAL_GAIN:
					cfg_q.lateral_gain <= pwdata[rcmw_pkg::GAIN_W-1:0];
				rcmw_pkg::REG_ROTATION_GAIN:
					cfg_q.rotation_gain <= pwdata[rcmw_pkg::GAIN_W-1:0];
				rcmw_pkg::REG_CENTER_WIDTH:
					cfg_q.center_width <= pwdata[rcmw_pkg::WIDTH_W-1:0];
				rcmw_pkg::REG_DEADBAND_WIDTH:
					cfg_q.deadband_width <= pwdata[rcmw_pkg::WIDTH_W-1:0];
				rcmw_pkg::REG_MAX_VALID_WIDTH:
					cfg_q.max_valid_width <= pwdata[rcmw_pkg::WIDTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			rcmw_pkg::REG_FORWARD_GAIN:    prdata = rcmw_pkg::DATA_W'(cfg_q.forward_gain);
			rcmw_pkg::REG_LATERAL_GAIN:    prdata = rcmw_pkg::DATA_W'(cfg_q.lateral_gain);
			rcmw_pkg::REG_ROTATION_GAIN:   prdata = rcmw_pkg::DATA_W'(cfg_q.rotation_gain);
			rcmw_pkg::REG_CENTER_WIDTH:    prdata = rcmw_pkg::DATA_W'(cfg_q.center_width);
			rcmw_pkg::REG_DEADBAND_WIDTH:  prdata = rcmw_pkg::DATA_W'(cfg_q.deadband_width);
			rcmw_pkg::REG_MAX_VALID_WIDTH: prdata = rcmw_pkg::DATA_W'(cfg_q.max_valid_width);
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== design/rc_pulse_to_mecanum_wheel_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_to_mecanum_wheel_speed
// Radio pulse widths to four mecanum wheel target speeds.
// ----------------------------------------------------------------------------
// The block takes one request of three pulse widths per clock while pulse.ready
// is high and returns one request of four saturated wheel speeds plus a hold
// flag for each channel through the pipeline registers. It runs as a
// four-stage pipeline: input register, hold/deadband/gain multiply, wheel
// sums and scaling, then the reciprocal multiply that divides by 125 and
// the output register. Each stage advances on its own, so a stalled output
// fills the pipeline before pulse.ready drops. A width above the maximum is
// replaced by the channel's last kept width (1500 after reset) and its bit
// in held_mask is set. The user must write registers over the APB port only
// while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rc_pulse_to_mecanum_wheel_speed (
	input  logic                        clk,
	input  logic                        arst_n,
	rcmw_pulse_if.sink                  pulse,
	rcmw_speed_if.source                speed,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rcmw_pkg::ADDR_W-1:0] paddr,
	input  logic [rcmw_pkg::DATA_W-1:0] pwdata,
	output logic [rcmw_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	rcmw_pkg::cfg_t cfg;

	// Stage handshake
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	// Stage 1: captured pulses
	logic [rcmw_pkg::PULSE_W-1:0] pulse_s1 [rcmw_pkg::N_CH];

	// Channel state
	logic [rcmw_pkg::WIDTH_W-1:0] last_valid_q [rcmw_pkg::N_CH];

	// Stage 1 logic
	logic [rcmw_pkg::GAIN_W-1:0]         gain     [rcmw_pkg::N_CH];
	logic [rcmw_pkg::WIDTH_W-1:0]        kept     [rcmw_pkg::N_CH];
	logic signed [rcmw_pkg::PROD_W-1:0]  prod     [rcmw_pkg::N_CH];
	logic [rcmw_pkg::N_CH-1:0]           held;

	// Stage 2: weighted offsets
	logic signed [rcmw_pkg::PROD_W-1:0]  prod_s2  [rcmw_pkg::N_CH];
	logic [rcmw_pkg::N_CH-1:0]           held_s2;

	// Stage 2 logic
	logic signed [rcmw_pkg::SUM_W-1:0]   fe, le, re;
	logic signed [rcmw_pkg::SUM_W-1:0]   sum      [rcmw_pkg::N_WHEEL];
	logic [rcmw_pkg::SUM_W-1:0]          mag      [rcmw_pkg::N_WHEEL];

	// Stage 3: scaled magnitudes
	logic [rcmw_pkg::Y_W-1:0]            y_s3     [rcmw_pkg::N_WHEEL];
	logic [rcmw_pkg::N_WHEEL-1:0]        neg_s3;
	logic [rcmw_pkg::N_CH-1:0]           held_s3;

	// Stage 4: output
	logic signed [rcmw_pkg::SPEED_W-1:0] speed_s4 [rcmw_pkg::N_WHEEL];
	logic [rcmw_pkg::N_CH-1:0]           held_s4;

	rcmw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance each stage when it is empty or the next one moves
	assign en4 = !valid_s4 || speed.ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pulse.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= pulse.valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (en1 && pulse.valid) begin
			pulse_s1[rcmw_pkg::CH_FORWARD]  <= pulse.forward_pulse;
			pulse_s1[rcmw_pkg::CH_LATERAL]  <= pulse.lateral_pulse;
			pulse_s1[rcmw_pkg::CH_ROTATION] <= pulse.rotation_pulse;
		end
	end

	// Hold invalid widths, take offset, apply deadband and gain
	assign gain[rcmw_pkg::CH_FORWARD]  = cfg.forward_gain;
	assign gain[rcmw_pkg::CH_LATERAL]  = cfg.lateral_gain;
	assign gain[rcmw_pkg::CH_ROTATION] = cfg.rotation_gain;

	always_comb begin
		for (int ch = 0; ch < rcmw_pkg::N_CH; ch++) begin
			held[ch] = pulse_s1[ch] > rcmw_pkg::PULSE_W'(cfg.max_valid_width);
			kept[ch] = held[ch] ? last_valid_q[ch] : pulse_s1[ch][rcmw_pkg::WIDTH_W-1:0];
			prod[ch] = rcmw_pkg::weigh(gain[ch],
				rcmw_pkg::offset_db(kept[ch], cfg.center_width, cfg.deadband_width));
		end
	end

	// Remember the kept width as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < rcmw_pkg::N_CH; ch++) begin
				last_valid_q[ch] <= rcmw_pkg::LAST_VALID_RST;
			end
		end else if (en2 && valid_s1) begin
			for (int ch = 0; ch < rcmw_pkg::N_CH; ch++) begin
				last_valid_q[ch] <= kept[ch];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			for (int ch = 0; ch < rcmw_pkg::N_CH; ch++) begin
				prod_s2[ch] <= prod[ch];
			end
			held_s2 <= held;
		end
	end

	// Form the four wheel sums and their magnitudes
	always_comb begin
		fe = rcmw_pkg::sext(prod_s2[rcmw_pkg::CH_FORWARD]);
		le = rcmw_pkg::sext(prod_s2[rcmw_pkg::CH_LATERAL]);
		re = rcmw_pkg::sext(prod_s2[rcmw_pkg::CH_ROTATION]);
		sum[rcmw_pkg::WH_RIGHT_FRONT] = fe - le + re;
		sum[rcmw_pkg::WH_LEFT_FRONT]  = fe + le - re;
		sum[rcmw_pkg::WH_LEFT_REAR]   = fe - le - re;
		sum[rcmw_pkg::WH_RIGHT_REAR]  = fe + le + re;
		for (int wh = 0; wh < rcmw_pkg::N_WHEEL; wh++) begin
			mag[wh] = sum[wh][rcmw_pkg::SUM_W-1] ? rcmw_pkg::SUM_W'(-sum[wh])
			                                     : rcmw_pkg::SUM_W'(sum[wh]);
		end
	end

	// Drop the gain fraction and the power-of-two part of 4000
	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			for (int wh = 0; wh < rcmw_pkg::N_WHEEL; wh++) begin
				y_s3[wh]   <= mag[wh][rcmw_pkg::MAG_W-1:
				                      rcmw_pkg::GAIN_FRAC_BITS + rcmw_pkg::SCALE_SHIFT];
				neg_s3[wh] <= sum[wh][rcmw_pkg::SUM_W-1];
			end
			held_s3 <= held_s2;
		end
	end

	// Divide by 125, restore the sign, saturate
	always_ff @(posedge clk) begin
		if (en4 && valid_s3) begin
			for (int wh = 0; wh < rcmw_pkg::N_WHEEL; wh++) begin
				speed_s4[wh] <= rcmw_pkg::wheel_speed(neg_s3[wh], y_s3[wh]);
			end
			held_s4 <= held_s3;
		end
	end

	assign speed.valid             = valid_s4;
	assign speed.right_front_speed = speed_s4[rcmw_pkg::WH_RIGHT_FRONT];
	assign speed.left_front_speed  = speed_s4[rcmw_pkg::WH_LEFT_FRONT];
	assign speed.left_rear_speed   = speed_s4[rcmw_pkg::WH_LEFT_REAR];
	assign speed.right_rear_speed  = speed_s4[rcmw_pkg::WH_RIGHT_REAR];
	assign speed.held_mask         = held_s4;

endmodule

// ===== design/rcmw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcmw_checker
// Port-level checks for the wheel speed block, bound to the top level.
// ----------------------------------------------------------------------------
module rcmw_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rcmw_pkg::SPEED_W-1:0] rf,
	input logic [rcmw_pkg::SPEED_W-1:0] lf,
	input logic [rcmw_pkg::SPEED_W-1:0] lr,
	input logic [rcmw_pkg::SPEED_W-1:0] rr,
	input logic [rcmw_pkg::N_CH-1:0]    held_mask,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [rcmw_pkg::ADDR_W-1:0] paddr,
	input logic [rcmw_pkg::DATA_W-1:0] pwdata,
	input logic [rcmw_pkg::DATA_W-1:0] prdata,
	input logic                        pready
);

	logic wr;
	assign wr = psel && penable && pwrite && pready;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({rf, lf, lr, rr, held_mask}))
		else $error("stalled result changed");

	// Never stretch a transfer
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// Read back a gain just written, upper byte cleared
	a_gain_rb: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(wr) && paddr[4:2] == $past(paddr[4:2])
		&& paddr[4:2] < rcmw_pkg::REG_CENTER_WIDTH
		|-> prdata == {8'h00, $past(pwdata[23:0])})
		else $error("gain readback mismatch");

	// Read back a width just written, upper bits cleared
	a_width_rb: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(wr) && paddr[4:2] == $past(paddr[4:2])
		&& paddr[4:2] >= rcmw_pkg::REG_CENTER_WIDTH
		&& paddr[4:2] <= rcmw_pkg::REG_MAX_VALID_WIDTH
		|-> prdata == {20'h00000, $past(pwdata[11:0])})
		else $error("width readback mismatch");

endmodule

bind rc_pulse_to_mecanum_wheel_speed rcmw_checker u_rcmw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (speed.valid),
	.out_ready (speed.ready),
	.rf        (speed.right_front_speed),
	.lf        (speed.left_front_speed),
	.lr        (speed.left_rear_speed),
	.rr        (speed.right_rear_speed),
	.held_mask (speed.held_mask),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.pready    (pready)
);
